@@ src/content_type_magic_sniffer_unit_macros.svh @@
// Assertion macros shared by the sniffer RTL.
`ifndef CONTENT_TYPE_MAGIC_SNIFFER_UNIT_MACROS_SVH
`define CONTENT_TYPE_MAGIC_SNIFFER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define CTMS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define CTMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/ctms_pkg.sv @@
`default_nettype none

package ctms_pkg;

	localparam int NUM_SIGS  = 20;
	localparam int WIN_BYTES = 18;
	localparam int HIST_DEPTH = WIN_BYTES - 1;
	localparam int WIN_W     = WIN_BYTES * 8;
	localparam int POS_W     = 13;
	localparam int NUM_KINDS = 4;

	typedef logic [WIN_W-1:0] win_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [NUM_KINDS-1:0] kind_mask_t;

	localparam pos_t POS_MAX    = '1;
	localparam pos_t CTRL_SPAN  = pos_t'(128);
	localparam logic [7:0] CTRL_BELOW = 8'd9;

	typedef enum logic [2:0] {
		KIND_HTML    = 3'd0,
		KIND_RTF     = 3'd1,
		KIND_RFC822  = 3'd2,
		KIND_DOCX    = 3'd3,
		KIND_DEFAULT = 3'd4,
		KIND_UNKNOWN = 3'd5,
		KIND_PLAIN   = 3'd6
	} kind_t;

	// Signature text right-justified: last character in the low byte.
	localparam win_t SIG_TEXT [NUM_SIGS] = '{
		win_t'("<!DOCTYPE HTML"),
		win_t'("<!doctype html"),
		win_t'("<HEAD"),
		win_t'("<head"),
		win_t'("<TITLE"),
		win_t'("<title"),
		win_t'("<HTML"),
		win_t'("<html"),
		win_t'("<!--"),
		win_t'("<H1"),
		win_t'("<h1"),
		win_t'("<BASE"),
		win_t'("<base"),
		win_t'("{\\rtf"),
		win_t'("Received: "),
		win_t'("\nReceived: "),
		win_t'("\nFrom: "),
		win_t'("\nTo: "),
		win_t'("\nSubject: "),
		win_t'({8'h00, "word/document.xml"})
	};

	localparam int SIG_LEN [NUM_SIGS] = '{
		14, 14, 5, 5, 6, 6, 5, 5, 4, 3, 3, 5, 5, 5, 10, 11, 7, 5, 10, 18
	};

	localparam int SIG_LIMIT [NUM_SIGS] = '{
		30, 30, 30, 30, 30, 30, 30, 30, 30, 30, 30, 30, 30,
		1, 1, 1024, 1024, 1024, 1024, 4096
	};

	localparam logic [1:0] SIG_KIND [NUM_SIGS] = '{
		2'(KIND_HTML), 2'(KIND_HTML), 2'(KIND_HTML), 2'(KIND_HTML), 2'(KIND_HTML),
		2'(KIND_HTML), 2'(KIND_HTML), 2'(KIND_HTML), 2'(KIND_HTML), 2'(KIND_HTML),
		2'(KIND_HTML), 2'(KIND_HTML), 2'(KIND_HTML),
		2'(KIND_RTF), 2'(KIND_RFC822), 2'(KIND_RFC822), 2'(KIND_RFC822),
		2'(KIND_RFC822), 2'(KIND_RFC822), 2'(KIND_DOCX)
	};

	// Byte mask covering the low len bytes of the window.
	function automatic win_t sig_mask(input int len);
		win_t m;
		m = '0;
		for (int i = 0; i < WIN_BYTES; i++) begin
			if (i < len) begin
				m[i*8 +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

`default_nettype wire

@@ src/content_type_magic_sniffer_unit.sv @@
// Channel  | Dir | Handshake           | Payload
// ---------+-----+---------------------+-------------------------------
// in       | in  | in_valid / in_stall | data_byte[7:0], last_byte
// out      | out | out_valid/out_stall | content_kind[2:0]
// cfg      | in  | cfg_wr_en           | cfg_wr_data (use_default_kind)
//
// One byte per cycle sustained while the output is not stalled. A byte lands
// in the input register, where all twenty signature compares run in parallel
// against the 17-byte history; once the result slot is free the kind of a
// last byte is written to the output register. Reset clears history,
// position, seen flags and the config bit. A stalled output blocks the input
// register only, so one more beat is taken while a result waits.
`default_nettype none

`include "content_type_magic_sniffer_unit_macros.svh"

module content_type_magic_sniffer_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      logic [2:0] content_kind,
	input  wire logic       cfg_wr_en,
	input  wire logic       cfg_wr_data
);

	// Input register stage
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// Per-document state
	logic [7:0]             hist_q [ctms_pkg::HIST_DEPTH];
	ctms_pkg::pos_t         pos_q;
	ctms_pkg::kind_mask_t   kind_seen_q;
	logic                   ctrl_seen_q;
	logic                   use_default_q;

	// Result register
	logic            out_valid_q;
	ctms_pkg::kind_t kind_q;

	logic                   advance;
	logic                   consume;
	logic                   in_accept;
	ctms_pkg::win_t         win;
	logic [ctms_pkg::NUM_SIGS-1:0] sig_hit;
	ctms_pkg::kind_mask_t   kind_hit;
	ctms_pkg::kind_mask_t   kind_all;
	logic                   ctrl_now;
	logic                   ctrl_all;
	ctms_pkg::kind_t        kind_next;

	// The result slot is free unless a result sits there stalled.
	assign advance   = !(out_valid_q && out_stall);
	assign consume   = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	assign out_valid    = out_valid_q;
	assign content_kind = kind_q;

	// Config register; the user must see that it is written only while idle, as the block has no guard for this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_default_q <= 1'b0;
		end else if (cfg_wr_en) begin
			use_default_q <= cfg_wr_data;
		end
	end

	// Input register: advance when the stage empties or hands its beat on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Window: current byte in the low byte, older bytes above it.
	always_comb begin
		win[7:0] = data_s1;
		for (int i = 0; i < ctms_pkg::HIST_DEPTH; i++) begin
			win[(i+1)*8 +: 8] = hist_q[i];
		end
	end

	// One comparator per signature. A signature ending on this byte started
	// at pos - len + 1; it needs that start inside the document and below
	// its window limit.
	for (genvar g = 0; g < ctms_pkg::NUM_SIGS; g++) begin : g_sig
		localparam ctms_pkg::win_t MASK = ctms_pkg::sig_mask(ctms_pkg::SIG_LEN[g]);
		localparam ctms_pkg::pos_t LO = ctms_pkg::pos_t'(ctms_pkg::SIG_LEN[g] - 1);
		localparam ctms_pkg::pos_t HI =
			ctms_pkg::pos_t'(ctms_pkg::SIG_LIMIT[g] + ctms_pkg::SIG_LEN[g] - 1);
		assign sig_hit[g] = ((win & MASK) == ctms_pkg::SIG_TEXT[g]) &&
			(pos_q >= LO) && (pos_q < HI);
	end

	// Fold signature hits into kind bits.
	always_comb begin
		kind_hit = '0;
		for (int i = 0; i < ctms_pkg::NUM_SIGS; i++) begin
			kind_hit[ctms_pkg::SIG_KIND[i]] = kind_hit[ctms_pkg::SIG_KIND[i]] | sig_hit[i];
		end
	end

	assign ctrl_now = (pos_q < ctms_pkg::CTRL_SPAN) && (data_s1 < ctms_pkg::CTRL_BELOW);
	assign kind_all = kind_seen_q | kind_hit;
	assign ctrl_all = ctrl_seen_q | ctrl_now;

	// Lowest set kind bit wins, then the fallbacks.
	always_comb begin
		if (kind_all[0]) begin
			kind_next = ctms_pkg::KIND_HTML;
		end else if (kind_all[1]) begin
			kind_next = ctms_pkg::KIND_RTF;
		end else if (kind_all[2]) begin
			kind_next = ctms_pkg::KIND_RFC822;
		end else if (kind_all[3]) begin
			kind_next = ctms_pkg::KIND_DOCX;
		end else if (use_default_q) begin
			kind_next = ctms_pkg::KIND_DEFAULT;
		end else if (ctrl_all) begin
			kind_next = ctms_pkg::KIND_UNKNOWN;
		end else begin
			kind_next = ctms_pkg::KIND_PLAIN;
		end
	end

	// Document state: advance on each consumed beat, drop back to reset on
	// the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ctms_pkg::HIST_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			pos_q       <= '0;
			kind_seen_q <= '0;
			ctrl_seen_q <= 1'b0;
		end else if (consume) begin
			if (last_s1) begin
				for (int i = 0; i < ctms_pkg::HIST_DEPTH; i++) begin
					hist_q[i] <= '0;
				end
				pos_q       <= '0;
				kind_seen_q <= '0;
				ctrl_seen_q <= 1'b0;
			end else begin
				hist_q[0] <= data_s1;
				for (int i = 1; i < ctms_pkg::HIST_DEPTH; i++) begin
					hist_q[i] <= hist_q[i-1];
				end
				if (pos_q != ctms_pkg::POS_MAX) begin
					pos_q <= pos_q + ctms_pkg::pos_t'(1);
				end
				kind_seen_q <= kind_all;
				ctrl_seen_q <= ctrl_all;
			end
		end
	end

	// Result register: load on a consumed last beat, release when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= consume && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			kind_q <= kind_next;
		end
	end

	`CTMS_ASSERT_NEXT(a_last_gives_result, consume && last_s1, out_valid_q,
		"last beat did not produce a result")
	`CTMS_ASSERT_NEXT(a_last_clears_doc, consume && last_s1,
		pos_q == '0 && kind_seen_q == '0 && !ctrl_seen_q,
		"document state not cleared after last beat")
	`CTMS_ASSERT_NOW(a_default_needs_cfg,
		out_valid_q && kind_q == ctms_pkg::KIND_DEFAULT, use_default_q,
		"default kind reported with default disabled")
	`CTMS_ASSERT_NOW(a_stall_needs_item, in_stall, valid_s1 && out_valid_q,
		"input stalled without a held beat and a waiting result")

endmodule

`default_nettype wire

@@ test/content_type_magic_sniffer_unit_tb.sv @@
`timescale 1ns / 1ps

module content_type_magic_sniffer_unit_tb;

	// Signature table and document rules, written apart from the RTL package; only the kind codes come from it.
	localparam int NSIG        = 20;
	localparam int WIN_N       = 18;
	localparam int HIST_N      = WIN_N - 1;
	localparam int POS_SAT     = 8191;
	localparam int CTRL_SPAN   = 128;
	localparam int CTRL_BELOW  = 9;
	localparam int SIG_H1      = 10;
	localparam int SIG_DOCTYPE = 0;
	localparam int SIG_COMMENT = 8;
	localparam int SIG_RTF     = 13;
	localparam int SIG_RCVD    = 14;
	localparam int SIG_NL_RCVD = 15;
	localparam int SIG_FROM    = 16;
	localparam int SIG_TO      = 17;
	localparam int SIG_SUBJECT = 18;
	// The docx signature carries a leading NUL byte in front of its text.
	localparam int SIG_DOCX    = 19;

	localparam int RAND_BYTES   = 600;
	localparam int QUIET_CYCLES = 4;
	localparam int TAIL_CYCLES  = 8;
	localparam int STUCK_LIMIT  = 1000;
	localparam int IDLE_PCT     = 32;
	localparam int REPORT_MAX   = 10;
	localparam logic [7:0] FILL = "x";

	string sig_txt [NSIG] = '{
		"<!DOCTYPE HTML", "<!doctype html", "<HEAD", "<head", "<TITLE", "<title",
		"<HTML", "<html", "<!--", "<H1", "<h1", "<BASE", "<base", "{\\rtf",
		"Received: ", "\nReceived: ", "\nFrom: ", "\nTo: ", "\nSubject: ",
		"word/document.xml"
	};
	int sig_limit [NSIG] = '{
		30, 30, 30, 30, 30, 30, 30, 30, 30, 30, 30, 30, 30,
		1, 1, 1024, 1024, 1024, 1024, 4096
	};
	ctms_pkg::kind_t sig_kind [NSIG] = '{
		ctms_pkg::KIND_HTML, ctms_pkg::KIND_HTML, ctms_pkg::KIND_HTML,
		ctms_pkg::KIND_HTML, ctms_pkg::KIND_HTML, ctms_pkg::KIND_HTML,
		ctms_pkg::KIND_HTML, ctms_pkg::KIND_HTML, ctms_pkg::KIND_HTML,
		ctms_pkg::KIND_HTML, ctms_pkg::KIND_HTML, ctms_pkg::KIND_HTML,
		ctms_pkg::KIND_HTML,
		ctms_pkg::KIND_RTF, ctms_pkg::KIND_RFC822, ctms_pkg::KIND_RFC822,
		ctms_pkg::KIND_RFC822, ctms_pkg::KIND_RFC822, ctms_pkg::KIND_RFC822,
		ctms_pkg::KIND_DOCX
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] content_kind;
	logic       cfg_wr_en;
	logic       cfg_wr_data;

	// Sniffer state as the testbench sees it.
	logic [7:0] hist [HIST_N];
	int         doc_pos;
	logic [3:0] seen_mask;
	bit         low_byte_seen;
	bit         dflt_kind_en;

	ctms_pkg::kind_t kind_expected_q [$];
	ctms_pkg::kind_t kind_want;
	logic [7:0] doc_buf [$];

	bit steady;
	int bytes_sent;
	int docs_sent;
	int kinds_checked;
	int mismatch_cnt;
	int stuck_cycles;
	int kind_tally [7];

	content_type_magic_sniffer_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.content_kind (content_kind),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	always #5 clk = ~clk;

	function automatic int sig_len(input int s);
		return sig_txt[s].len() + ((s == SIG_DOCX) ? 1 : 0);
	endfunction

	function automatic logic [7:0] sig_byte(input int s, input int j);
		if (s == SIG_DOCX) begin
			return (j == 0) ? 8'h00 : sig_txt[s][j-1];
		end
		return sig_txt[s][j];
	endfunction

	function automatic void clear_doc_state();
		for (int i = 0; i < HIST_N; i++) begin
			hist[i] = 8'h00;
		end
		doc_pos = 0;
		seen_mask = '0;
		low_byte_seen = 1'b0;
	endfunction

	// Advance the sniffer by one accepted beat; queue the kind on a last byte.
	function automatic void sniff_byte(input logic [7:0] b, input bit last);
		logic [7:0] win [WIN_N];
		int slen;
		int start;
		bit hit;
		ctms_pkg::kind_t k;
		win[WIN_N-1] = b;
		for (int i = 0; i < HIST_N; i++) begin
			win[WIN_N-2-i] = hist[i];
		end
		// Compare all signatures that end on this byte and start inside their window.
		for (int s = 0; s < NSIG; s++) begin
			slen = sig_len(s);
			if (doc_pos + 1 < slen) begin
				continue;
			end
			start = doc_pos + 1 - slen;
			if (start >= sig_limit[s]) begin
				continue;
			end
			hit = 1'b1;
			for (int j = 0; j < slen; j++) begin
				if (win[WIN_N-slen+j] != sig_byte(s, j)) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				seen_mask[int'(sig_kind[s])] = 1'b1;
			end
		end
		if (doc_pos < CTRL_SPAN && b < CTRL_BELOW) begin
			low_byte_seen = 1'b1;
		end
		for (int i = HIST_N - 1; i > 0; i--) begin
			hist[i] = hist[i-1];
		end
		hist[0] = b;
		if (doc_pos < POS_SAT) begin
			doc_pos++;
		end
		if (last) begin
			if (seen_mask[int'(ctms_pkg::KIND_HTML)]) begin
				k = ctms_pkg::KIND_HTML;
			end else if (seen_mask[int'(ctms_pkg::KIND_RTF)]) begin
				k = ctms_pkg::KIND_RTF;
			end else if (seen_mask[int'(ctms_pkg::KIND_RFC822)]) begin
				k = ctms_pkg::KIND_RFC822;
			end else if (seen_mask[int'(ctms_pkg::KIND_DOCX)]) begin
				k = ctms_pkg::KIND_DOCX;
			end else if (dflt_kind_en) begin
				k = ctms_pkg::KIND_DEFAULT;
			end else if (low_byte_seen) begin
				k = ctms_pkg::KIND_UNKNOWN;
			end else begin
				k = ctms_pkg::KIND_PLAIN;
			end
			kind_expected_q.push_back(k);
			clear_doc_state();
		end
	endfunction

	function automatic void flag_kind_error(input string what, input logic [2:0] want,
			input logic [2:0] got);
		mismatch_cnt++;
		if (mismatch_cnt <= REPORT_MAX) begin
			$display("[%0t] %s: content_kind expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	// Send one beat: idle at random first (never when steady), then hold the beat until it is taken.
	task automatic send_byte(input logic [7:0] b, input bit last);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sniff_byte(b, last);
		bytes_sent++;
		if (last) begin
			docs_sent++;
		end
		@(negedge clk);
	endtask

	task automatic send_doc();
		for (int i = 0; i < doc_buf.size(); i++) begin
			send_byte(doc_buf[i], i == doc_buf.size() - 1);
		end
	endtask

	task automatic send_text(input string t);
		doc_buf.delete();
		for (int i = 0; i < t.len(); i++) begin
			doc_buf.push_back(t[i]);
		end
		send_doc();
	endtask

	task automatic pad_to(input int n);
		while (doc_buf.size() < n) begin
			doc_buf.push_back(FILL);
		end
	endtask

	task automatic put_sig(input int s);
		for (int j = 0; j < sig_len(s); j++) begin
			doc_buf.push_back(sig_byte(s, j));
		end
	endtask

	// Filler, then signature s starting at byte at, then tail filler bytes.
	task automatic sig_at_doc(input int s, input int at, input int tail);
		doc_buf.delete();
		pad_to(at);
		put_sig(s);
		pad_to(doc_buf.size() + tail);
		send_doc();
	endtask

	task automatic ctrl_at_doc(input int at, input logic [7:0] b);
		doc_buf.delete();
		pad_to(at);
		doc_buf.push_back(b);
		pad_to(at + 3);
		send_doc();
	endtask

	// Drop valid and wait until every queued kind is out, plus a quiet gap.
	task automatic drain();
		in_valid <= 1'b0;
		while (kind_expected_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_default_kind(input bit v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		dflt_kind_en = v;
	endtask

	task automatic make_random_doc();
		int n;
		int r;
		int mode;
		int s;
		int at;
		doc_buf.delete();
		r = $urandom_range(0, 99);
		n = (r < 70) ? $urandom_range(1, 40) :
			(r < 95) ? $urandom_range(41, 160) : $urandom_range(161, 400);
		mode = $urandom_range(0, 2);
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: begin
					doc_buf.push_back(8'($urandom_range(32, 126)));
				end
				1: begin
					doc_buf.push_back(8'($urandom_range(0, 255)));
				end
				default: begin
					doc_buf.push_back(($urandom_range(0, 29) == 0) ?
						8'($urandom_range(0, CTRL_BELOW - 1)) :
						8'($urandom_range(CTRL_BELOW, 126)));
				end
			endcase
		end
		// Embed signatures near the document start, around the short window limits; some run off the end of the document.
		if ($urandom_range(0, 99) < 65) begin
			repeat ($urandom_range(1, 2)) begin
				s = $urandom_range(0, NSIG - 1);
				at = (sig_limit[s] == 1) ? $urandom_range(0, 2) :
					(sig_limit[s] == 30) ? $urandom_range(0, 34) : $urandom_range(0, 60);
				if ($urandom_range(0, 99) < 70) begin
					while (doc_buf.size() < at + sig_len(s)) begin
						doc_buf.push_back(8'($urandom_range(32, 126)));
					end
				end
				for (int j = 0; j < sig_len(s); j++) begin
					if (at + j < doc_buf.size()) begin
						doc_buf[at+j] = sig_byte(s, j);
					end
				end
			end
		end
	endtask

	// Single-byte documents at the field extremes and the control threshold,
	// short signature hits and misses, and the default kind in both settings.
	task automatic test_directed();
		write_default_kind(1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h08, 1'b1);
		send_byte(8'h09, 1'b1);
		send_text("<h1");
		send_text("<!-");
		send_text("{\\rtf");
		write_default_kind(1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b1);
		send_text("<H1");
	endtask

	// Start positions on both sides of the short window limits, and early
	// starts for the signatures with long windows.
	task automatic test_window_limits();
		write_default_kind(1'b0);
		sig_at_doc(SIG_COMMENT, 29, 0);
		sig_at_doc(SIG_COMMENT, 30, 2);
		sig_at_doc(SIG_DOCTYPE, 15, 1);
		sig_at_doc(SIG_RTF, 0, 3);
		sig_at_doc(SIG_RTF, 1, 0);
		sig_at_doc(SIG_RCVD, 0, 0);
		sig_at_doc(SIG_RCVD, 1, 2);
		sig_at_doc(SIG_NL_RCVD, 2, 0);
		sig_at_doc(SIG_FROM, 0, 1);
		sig_at_doc(SIG_TO, 5, 1);
		sig_at_doc(SIG_SUBJECT, 3, 0);
		sig_at_doc(SIG_DOCX, 0, 0);
		sig_at_doc(SIG_DOCX, 7, 1);
		// Two kinds in one document: the earlier kind in the table wins.
		doc_buf.delete();
		put_sig(SIG_RCVD);
		put_sig(SIG_H1);
		send_doc();
	endtask

	task automatic test_control_window();
		write_default_kind(1'b0);
		ctrl_at_doc(CTRL_SPAN - 1, 8'h08);
		ctrl_at_doc(CTRL_SPAN, 8'h00);
		write_default_kind(1'b1);
		ctrl_at_doc(CTRL_SPAN - 1, 8'h00);
	endtask

	task automatic test_random_docs();
		int goal;
		for (int ph = 0; ph < 4; ph++) begin
			write_default_kind(ph == 1 || ph == 2);
			// Run one phase back to back on the input side, with no receiver stalls.
			steady = (ph == 2);
			goal = bytes_sent + RAND_BYTES / 4;
			while (bytes_sent < goal) begin
				make_random_doc();
				send_doc();
			end
		end
		steady = 1'b0;
	endtask

	// Receiver side: stall at random except during the steady stretch.
	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// Check each accepted kind against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (kind_expected_q.size() == 0) begin
				flag_kind_error("result with nothing expected", 3'bx, content_kind);
			end else begin
				kind_want = kind_expected_q.pop_front();
				kinds_checked++;
				kind_tally[int'(kind_want)]++;
				if (content_kind !== kind_want) begin
					flag_kind_error("kind mismatch", kind_want, content_kind);
				end
			end
		end
	end

	// Watchdog: end the run when neither channel moves a beat for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles + 1 >= STUCK_LIMIT) begin
				$display("[%0t] watchdog: no beat for %0d cycles, %0d kinds outstanding",
					$time, STUCK_LIMIT, kind_expected_q.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		data_byte   = 8'h00;
		last_byte   = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 1'b0;
		out_stall   = 1'b0;
		steady      = 1'b0;
		dflt_kind_en = 1'b0;
		stuck_cycles = 0;
		clear_doc_state();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_window_limits();
		test_control_window();
		test_random_docs();

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d documents (%0d bytes); checked %0d kinds, %0d mismatches.",
			docs_sent, bytes_sent, kinds_checked, mismatch_cnt);
		$display("Kinds: html %0d rtf %0d mail %0d docx %0d default %0d binary %0d text %0d",
			kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3],
			kind_tally[4], kind_tally[5], kind_tally[6]);
		if (mismatch_cnt == 0 && kind_expected_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
